/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL; all use clk_i and rst_ni of the module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define LBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition never occurs at a clock edge outside reset.
`define LBS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* hw/rtl/lbs_pkg.sv */
package lbs_pkg;

  localparam int NumBonesDef  = 256;
  localparam int FracBitsDef  = 16;
  localparam int WordsPerBone = 12;
  localparam int WeightFrac   = 15;
  localparam int QueueDepth   = 4;

  localparam logic [7:0] UnskinnedId = 8'd255;
  localparam logic       OpLoad      = 1'b0;
  localparam logic       OpSkin      = 1'b1;

  // Classification of a queued item
  typedef enum logic [1:0] {
    CMD_DROP,
    CMD_LOAD,
    CMD_SKIN,
    CMD_BYPASS
  } cmd_e;

  typedef struct packed {
    logic               opcode;
    logic        [7:0]  bone_slot;
    logic        [3:0]  entry_slot;
    logic signed [31:0] entry_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [31:0] skin_bones;
    logic        [63:0] weights;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               transformed;
  } out_t;

  typedef struct packed {
    cmd_e kind;
    in_t  item;
  } cmd_t;

endpackage

/* hw/rtl/lbs_front.sv */
module lbs_front #(
  parameter int NumBones = lbs_pkg::NumBonesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lbs_pkg::in_t  in_data_i,
  output logic          push_o,
  input  logic          full_i,
  output lbs_pkg::cmd_t cmd_o
);

  logic          valid_q;
  lbs_pkg::cmd_t cmd_q, cmd_d;
  logic          take;

  assign in_stall_o = valid_q && full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !full_i;
  assign cmd_o      = cmd_q;

  // classify the incoming transfer
  always_comb begin
    cmd_d.item = in_data_i;
    if (in_data_i.opcode == lbs_pkg::OpLoad) begin
      if (int'(in_data_i.bone_slot) < NumBones &&
          int'(in_data_i.entry_slot) < lbs_pkg::WordsPerBone) begin
        cmd_d.kind = lbs_pkg::CMD_LOAD;
      end else begin
        cmd_d.kind = lbs_pkg::CMD_DROP;
      end
    end else if (in_data_i.skin_bones[7:0] == lbs_pkg::UnskinnedId) begin
      cmd_d.kind = lbs_pkg::CMD_BYPASS;
    end else begin
      cmd_d.kind = lbs_pkg::CMD_SKIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

/* hw/rtl/lbs_fifo.sv */
module lbs_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lbs_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output lbs_pkg::cmd_t head_o
);

  localparam int PtrW = $clog2(lbs_pkg::QueueDepth);
  localparam int CntW = $clog2(lbs_pkg::QueueDepth + 1);

  lbs_pkg::cmd_t    slot_q [lbs_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o       = count_q == CntW'(lbs_pkg::QueueDepth);
  assign head_valid_o = count_q != '0;
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hw/rtl/lbs_back.sv */
`include "assert_macros.svh"

module lbs_back #(
  parameter int NumBones = lbs_pkg::NumBonesDef,
  parameter int FracBits = lbs_pkg::FracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  lbs_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lbs_pkg::out_t out_data_o
);

  localparam int Aw   = (NumBones > 1) ? $clog2(NumBones) : 1;
  localparam int Nw   = lbs_pkg::WordsPerBone;
  localparam int SumW = 67;

  logic en;
  logic is_skin, is_bypass, is_load;
  logic [1:0] k_q;
  logic [7:0] cur_id;
  logic [Aw-1:0] rd_addr, wr_addr;
  logic we;

  // issue stage / read data
  logic               a_v_q, a_first_q, a_last_q, a_zero_q, a_sent_q;
  logic        [15:0] a_w_q;
  logic signed [31:0] a_pos_q [3];
  logic signed [31:0] rd_q [Nw];

  // weighted products
  logic               b_v_q, b_first_q, b_last_q, b_sent_q;
  logic signed [31:0] b_pos_q [3];
  logic signed [48:0] b_p_q [Nw];

  // accumulation
  logic               c_v_q, c_sent_q;
  logic signed [31:0] c_pos_q [3];
  logic signed [50:0] acc_q [Nw];

  // blended matrix
  logic               d_v_q, d_sent_q;
  logic signed [31:0] d_pos_q [3];
  logic signed [31:0] blend_d [Nw];
  logic signed [31:0] blend_q [Nw];

  // row products
  logic               e_v_q, e_sent_q;
  logic signed [63:0] e_p_q [3][3];
  logic signed [31:0] e_bias_q [3];

  // output register
  logic               out_valid_q;
  lbs_pkg::out_t      out_q, out_d;

  assign en        = !out_valid_q || !out_stall_i;
  assign is_skin   = head_valid_i && head_i.kind == lbs_pkg::CMD_SKIN;
  assign is_bypass = head_valid_i && head_i.kind == lbs_pkg::CMD_BYPASS;
  assign is_load   = head_valid_i && head_i.kind == lbs_pkg::CMD_LOAD;
  assign pop_o     = en && head_valid_i && (!is_skin || k_q == 2'd3);
  assign cur_id    = head_i.item.skin_bones[8*k_q +: 8];
  assign rd_addr   = cur_id[Aw-1:0];
  assign wr_addr   = head_i.item.bone_slot[Aw-1:0];
  assign we        = en && is_load;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // palette, one bank per matrix entry
  for (genvar b = 0; b < Nw; b++) begin : g_bank
    logic [31:0] mem [NumBones];
    always_ff @(posedge clk_i) begin
      if (we && head_i.item.entry_slot == 4'(b)) begin
        mem[wr_addr] <= head_i.item.entry_value;
      end
      if (en) begin
        rd_q[b] <= mem[rd_addr];
      end
    end
  end

  // control: bone step counter and stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= 2'd0;
      a_v_q       <= 1'b0;
      b_v_q       <= 1'b0;
      c_v_q       <= 1'b0;
      d_v_q       <= 1'b0;
      e_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      if (is_skin) k_q <= k_q + 2'd1;
      a_v_q       <= is_skin || is_bypass;
      b_v_q       <= a_v_q;
      c_v_q       <= b_v_q && b_last_q;
      d_v_q       <= c_v_q;
      e_v_q       <= d_v_q;
      out_valid_q <= e_v_q;
    end
  end

  // blend rounding and saturation
  always_comb begin
    logic signed [50:0] t;
    logic signed [35:0] sh;
    for (int j = 0; j < Nw; j++) begin
      t  = acc_q[j] + 51'sd16384;
      sh = 36'(t >>> lbs_pkg::WeightFrac);
      if (sh > 36'sd2147483647) begin
        blend_d[j] = 32'sh7fffffff;
      end else if (sh < -36'sd2147483648) begin
        blend_d[j] = 32'sh80000000;
      end else begin
        blend_d[j] = 32'(sh);
      end
    end
  end

  // row sums, rounding and saturation
  always_comb begin
    logic signed [SumW-1:0] s;
    logic signed [SumW-1:0] q;
    logic signed [31:0]     r_v [3];
    for (int r = 0; r < 3; r++) begin
      s = SumW'(e_p_q[r][0]) + SumW'(e_p_q[r][1]) + SumW'(e_p_q[r][2])
        + (SumW'(e_bias_q[r]) <<< FracBits)
        + (SumW'(1) <<< (FracBits - 1));
      q = s >>> FracBits;
      if (q > SumW'(32'sh7fffffff)) begin
        r_v[r] = 32'sh7fffffff;
      end else if (q < SumW'(32'sh80000000)) begin
        r_v[r] = 32'sh80000000;
      end else begin
        r_v[r] = 32'(q);
      end
    end
    out_d.out_x       = e_sent_q ? 32'sd0 : r_v[0];
    out_d.out_y       = e_sent_q ? 32'sd0 : r_v[1];
    out_d.out_z       = e_sent_q ? 32'sd0 : r_v[2];
    out_d.transformed = !e_sent_q;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_first_q  <= is_bypass || k_q == 2'd0;
      a_last_q   <= is_bypass || k_q == 2'd3;
      a_zero_q   <= !(int'(cur_id) < NumBones);
      a_sent_q   <= is_bypass;
      a_w_q      <= head_i.item.weights[16*k_q +: 16];
      a_pos_q[0] <= head_i.item.pos_x;
      a_pos_q[1] <= head_i.item.pos_y;
      a_pos_q[2] <= head_i.item.pos_z;

      b_first_q <= a_first_q;
      b_last_q  <= a_last_q;
      b_sent_q  <= a_sent_q;
      b_pos_q   <= a_pos_q;
      for (int j = 0; j < Nw; j++) begin
        b_p_q[j] <= a_zero_q ? 49'sd0 : $signed({1'b0, a_w_q}) * rd_q[j];
      end

      if (b_v_q) begin
        for (int j = 0; j < Nw; j++) begin
          acc_q[j] <= (b_first_q ? 51'sd0 : acc_q[j]) + 51'(b_p_q[j]);
        end
        if (b_last_q) begin
          c_sent_q <= b_sent_q;
          c_pos_q  <= b_pos_q;
        end
      end

      d_sent_q <= c_sent_q;
      d_pos_q  <= c_pos_q;
      blend_q  <= blend_d;

      e_sent_q <= d_sent_q;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          e_p_q[r][c] <= blend_q[r*4+c] * d_pos_q[c];
        end
        e_bias_q[r] <= blend_q[r*4+3];
      end

      out_q <= out_d;
    end
  end

  `LBS_ASSERT(a_step_head, (k_q != 2'd0) |-> (head_valid_i && head_i.kind == lbs_pkg::CMD_SKIN), "bone step without skin item")
  `LBS_NEVER(a_pop_stall, pop_o && out_valid_q && out_stall_i, "queue pop while output stalled")
  `LBS_ASSERT(a_sent_zero, (out_valid_q && !out_q.transformed) |-> (out_q.out_x == 32'sd0 && out_q.out_y == 32'sd0 && out_q.out_z == 32'sd0), "unskinned vertex with nonzero position")

endmodule

/* hw/rtl/linear_blend_skinning.sv */
// Skinning vertex: the back end reads the four bones from the entry-banked palette, one
// bone per cycle while the output is not stalled, and takes the next item only after the fourth.
// Palette loads and unskinned vertices are popped without bone reads; loads give no result.
// Reset (rst_ni low, asynchronous) empties the queue and pipeline; palette contents are
// left as they are and must be loaded before use.
module linear_blend_skinning #(
  parameter int NumBones = lbs_pkg::NumBonesDef,
  parameter int FracBits = lbs_pkg::FracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lbs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lbs_pkg::out_t out_data_o
);

  logic          push, full, pop, head_valid;
  lbs_pkg::cmd_t push_cmd, head;

  lbs_front #(.NumBones(NumBones)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .full_i     (full),
    .cmd_o      (push_cmd)
  );

  lbs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  lbs_back #(.NumBones(NumBones), .FracBits(FracBits)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

/* tb/lbs_checker.sv */
// Watches both channels of the skinning block, predicts each vertex result
// from a private palette copy and compares transfers in order.
module lbs_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  lbs_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  lbs_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o
);

  logic [31:0]   palette_copy [lbs_pkg::NumBonesDef*lbs_pkg::WordsPerBone];
  lbs_pkg::out_t expected_pos [$];

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat_word(logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -128'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // weight-blend four matrices, then apply the blend to (x,y,z,1); unskinned gives all zero
  function automatic lbs_pkg::out_t skin_vertex(lbs_pkg::in_t v);
    lbs_pkg::out_t       r;
    longint              acc;
    logic signed [31:0]  blend [4];
    logic signed [127:0] sum;
    logic [7:0]          id;
    longint              w;
    r = '0;
    if (v.skin_bones[7:0] == lbs_pkg::UnskinnedId) return r;
    for (int row = 0; row < 3; row++) begin
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          id  = v.skin_bones[8*k +: 8];
          w   = longint'(v.weights[16*k +: 16]);
          acc += w * longint'($signed(
            palette_copy[int'(id)*lbs_pkg::WordsPerBone + row*4 + c]));
        end
        acc += longint'(1) << (lbs_pkg::WeightFrac - 1);
        blend[c] = sat_word(128'(acc >>> lbs_pkg::WeightFrac));
      end
      sum = 128'(blend[0]) * 128'(v.pos_x) + 128'(blend[1]) * 128'(v.pos_y)
          + 128'(blend[2]) * 128'(v.pos_z) + (128'(blend[3]) <<< lbs_pkg::FracBitsDef)
          + (128'sd1 <<< (lbs_pkg::FracBitsDef - 1));
      case (row)
        0: r.out_x = sat_word(sum >>> lbs_pkg::FracBitsDef);
        1: r.out_y = sat_word(sum >>> lbs_pkg::FracBitsDef);
        default: r.out_z = sat_word(sum >>> lbs_pkg::FracBitsDef);
      endcase
    end
    r.transformed = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    lbs_pkg::out_t want;
    if (rst_ni) begin
      // input transfer: update palette copy or queue a prediction
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.opcode == lbs_pkg::OpLoad) begin
          if (in_data_i.entry_slot < lbs_pkg::WordsPerBone)
            palette_copy[int'(in_data_i.bone_slot)*lbs_pkg::WordsPerBone
                         + in_data_i.entry_slot] = in_data_i.entry_value;
        end else begin
          expected_pos.push_back(skin_vertex(in_data_i));
        end
      end
      // output transfer: compare with oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_pos.size() == 0) begin
          report_mismatch("result count", 1, 0);
        end else begin
          want = expected_pos.pop_front();
          if (out_data_i.out_x !== want.out_x)
            report_mismatch("out_x", out_data_i.out_x, want.out_x);
          if (out_data_i.out_y !== want.out_y)
            report_mismatch("out_y", out_data_i.out_y, want.out_y);
          if (out_data_i.out_z !== want.out_z)
            report_mismatch("out_z", out_data_i.out_z, want.out_z);
          if (out_data_i.transformed !== want.transformed)
            report_mismatch("transformed", out_data_i.transformed, want.transformed);
        end
      end
      pending_o = expected_pos.size();
    end
  end

endmodule

/* tb/tb_top.sv */
module tb_top;

  localparam int IdleLimit = 5000;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  lbs_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  lbs_pkg::out_t out_data;
  int    fail_count;
  int    pending;
  int    items_sent;
  int    idle_cycles;
  bit    quiet;
  bit    bone_ready [256];
  logic [7:0] ready_bones [$];

  linear_blend_skinning dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  lbs_checker checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold-off
  initial begin
    bit held;
    held = 0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && items_sent >= 300) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // one transfer; valid stays high on return
  task automatic send(lbs_pkg::in_t it);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // item with every field random
  function automatic lbs_pkg::in_t rand_item();
    logic [287:0] raw;
    for (int i = 0; i < 9; i++) raw[32*i +: 32] = $urandom;
    return raw[$bits(lbs_pkg::in_t)-1:0];
  endfunction

  task automatic load_word(logic [7:0] bone, logic [3:0] slot, logic [31:0] value);
    lbs_pkg::in_t it;
    it = rand_item();
    it.opcode      = lbs_pkg::OpLoad;
    it.bone_slot   = bone;
    it.entry_slot  = slot;
    it.entry_value = value;
    send(it);
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000);
    endcase
  endfunction

  // full matrix of random words for one bone, in random order
  task automatic load_bone(logic [7:0] bone);
    int order [12];
    for (int i = 0; i < 12; i++) order[i] = i;
    order.shuffle();
    for (int i = 0; i < 12; i++) load_word(bone, 4'(order[i]), rand_entry());
    if (!bone_ready[bone]) begin
      bone_ready[bone] = 1;
      ready_bones.push_back(bone);
    end
  endtask

  task automatic skin(logic [31:0] ids, logic [63:0] w, logic [31:0] x, logic [31:0] y,
                      logic [31:0] z);
    lbs_pkg::in_t it;
    it = rand_item();
    it.opcode     = lbs_pkg::OpSkin;
    it.skin_bones = ids;
    it.weights    = w;
    it.pos_x      = x;
    it.pos_y      = y;
    it.pos_z      = z;
    send(it);
  endtask

  task automatic random_vertex();
    logic [31:0] ids;
    logic [63:0] w;
    for (int k = 0; k < 4; k++)
      ids[8*k +: 8] = ready_bones[$urandom_range(0, ready_bones.size() - 1)];
    case ($urandom_range(0, 3))
      0: w = {$urandom, $urandom};
      1: w = {16'($urandom_range(0, 16'h1FFF)), 16'($urandom_range(0, 16'h1FFF)),
              16'($urandom_range(0, 16'h1FFF)), 16'($urandom_range(0, 16'h1FFF))};
      default: w = 64'(16'($urandom_range(0, 16'h8000))) << (16 * $urandom_range(0, 3));
    endcase
    skin(ids, w, rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    int counted;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    quiet      = 0;
    items_sent = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: identity-like bone 0, extreme bone 255
    for (int i = 0; i < 12; i++)
      load_word(8'd0, 4'(i), (i % 5 == 0) ? 32'h0001_0000 : 32'(i * 32'h0000_4000));
    for (int i = 0; i < 12; i++)
      load_word(8'd255, 4'(i), i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    bone_ready[0] = 1;
    bone_ready[255] = 1;
    ready_bones.push_back(8'd0);
    ready_bones.push_back(8'd255);
    load_word(8'd7, 4'd15, 32'hFFFF_FFFF);   // ignored load, entry out of range
    load_word(8'd7, 4'd12, 32'h1234_5678);   // ignored load
    skin(32'h0000_0000, 64'h0000_0000_0000_8000, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
    skin(32'hFFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    skin(32'hFFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    skin(32'h0000_0000, 64'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    skin(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h2);  // unskinned
    skin(32'h0102_03FF, 64'h0, 32'h0, 32'h0, 32'h0);                          // unskinned

    // random: matrix loads, ignored loads, unskinned vertices and vertices on loaded bones
    counted = 0;
    while (counted < 900) begin
      if (items_sent >= 600 && items_sent < 615) begin
        // sender pause until every result is back
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        items_sent = 615;
      end
      quiet = (counted > 780);
      case ($urandom_range(0, 19))
        0, 1: begin
          load_bone(8'($urandom));
          counted += 12;
        end
        2: load_word(8'($urandom), 4'($urandom_range(12, 15)), $urandom);
        3: begin
          skin({8'($urandom), 8'($urandom), 8'($urandom), lbs_pkg::UnskinnedId},
               {$urandom, $urandom}, $urandom, $urandom, $urandom);
          counted++;
        end
        default: begin
          random_vertex();
          counted++;
        end
      endcase
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
